@@ hw/rtl/nfsu_pkg.sv @@
// Shared types, constants and helper functions for the neuron forward and SGD core.
// Used by nfsu_act and neuron_forward_and_sgd_update_core; depends on nothing.
`default_nettype none

package nfsu_pkg;

  localparam int MAX_INPUTS  = 64;
  localparam int PARAM_DEPTH = MAX_INPUTS + 1;
  localparam int PARAM_AW    = $clog2(PARAM_DEPTH);
  localparam int DATA_W      = 16;
  localparam int ACC_W       = 40;
  localparam int LR_W        = 16;
  localparam int COUNT_W     = 7;

  localparam logic [15:0] BETA_Q16 = 16'd58982;
  localparam logic [12:0] TANH_SAT = 13'd4093;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_GRAD = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RELU    = 2'd1,
    ACT_TANH    = 2'd2,
    ACT_SIGMOID = 2'd3
  } act_mode_t;

  typedef enum logic [1:0] {
    CFG_ACT_MODE = 2'd0,
    CFG_LR       = 2'd1,
    CFG_MOM_EN   = 2'd2,
    CFG_IN_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_MUL,
    ST_F_ACC,
    ST_F_BIAS,
    ST_F_RND,
    ST_F_ACT,
    ST_G_MUL,
    ST_G_MOM,
    ST_G_CHG,
    ST_G_WR
  } state_t;

  // tanh(k/4) in Q4.12 for k = 0..16.
  function automatic logic [12:0] tanh_lut(input logic [4:0] k);
    logic [12:0] t;
    case (k)
      5'd0:    t = 13'd0;
      5'd1:    t = 13'd1003;
      5'd2:    t = 13'd1893;
      5'd3:    t = 13'd2602;
      5'd4:    t = 13'd3119;
      5'd5:    t = 13'd3475;
      5'd6:    t = 13'd3707;
      5'd7:    t = 13'd3856;
      5'd8:    t = 13'd3949;
      5'd9:    t = 13'd4006;
      5'd10:   t = 13'd4041;
      5'd11:   t = 13'd4062;
      5'd12:   t = 13'd4076;
      5'd13:   t = 13'd4084;
      5'd14:   t = 13'd4089;
      5'd15:   t = 13'd4091;
      5'd16:   t = 13'd4093;
      default: t = 13'd0;
    endcase
    return t;
  endfunction

  // Saturate a 20-bit signed value to the 16-bit data range.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nfsu_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module nfsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/nfsu_act.sv @@
// Activation unit: none, relu, interpolated tanh or sigmoid, with a registered result.
// Depends on nfsu_pkg for the mode type and the tanh table.
`default_nettype none

module nfsu_act (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire nfsu_pkg::act_mode_t mode,
  input  wire logic signed [15:0]  x,
  output logic                     valid,
  output logic signed [15:0]       y
);
  import nfsu_pkg::*;

  logic [16:0]        mag;
  logic [16:0]        tin;
  logic [3:0]         seg;
  logic [9:0]         frac;
  logic [12:0]        t_lo;
  logic [12:0]        t_hi;
  logic [9:0]         diff;
  logic [19:0]        prod;
  logic [19:0]        prod_rnd;
  logic [12:0]        tpos;
  logic [13:0]        sig_sum;
  logic signed [15:0] y_nxt;
  logic               valid_r;
  logic signed [15:0] y_r;

  always_comb begin
    mag  = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    // Sigmoid reuses the tanh curve at half the argument.
    tin  = (mode == ACT_SIGMOID) ? {1'b0, mag[16:1]} : mag;
    seg  = tin[13:10];
    frac = tin[9:0];
    t_lo = tanh_lut({1'b0, seg});
    t_hi = tanh_lut({1'b0, seg} + 5'd1);
    diff = 10'(t_hi - t_lo);
    prod = {10'd0, diff} * {10'd0, frac};
    prod_rnd = prod + 20'd512;
    tpos = (tin >= 17'd16384) ? TANH_SAT : t_lo + {3'd0, prod_rnd[19:10]};
    sig_sum = x[15] ? (14'd4097 - {1'b0, tpos}) : (14'd4097 + {1'b0, tpos});
    case (mode)
      ACT_NONE:    y_nxt = x;
      ACT_RELU:    y_nxt = x[15] ? 16'sd0 : x;
      ACT_TANH:    y_nxt = x[15] ? (16'sd0 - $signed({3'd0, tpos})) : $signed({3'd0, tpos});
      ACT_SIGMOID: y_nxt = $signed({3'd0, sig_sum[13:1]});
      default:     y_nxt = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fire;
    end
    if (fire) begin
      y_r <= y_nxt;
    end
  end

  assign valid = valid_r;
  assign y     = y_r;

endmodule

`default_nettype wire

@@ hw/rtl/neuron_forward_and_sgd_update_core.sv @@
// Neuron core: parameter table, forward MAC with activation, SGD update with momentum.
// Depends on nfsu_pkg, nfsu_ram, nfsu_act. Load, ignored and out-of-range gradient items
// leave the core idle; other items keep it busy, and no new item is taken meanwhile. With
// last set a forward item adds bias, rounding and activation steps before its result strobe.
// The receiver cannot stall results. Reset (sync, active low) restores register defaults
// and clears the accumulator and velocity marks.
`default_nettype none

module neuron_forward_and_sgd_update_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Item channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [6:0]          in_index,
  input  wire logic signed [15:0]  in_value,
  input  wire logic                in_last,
  // Result channel, one-cycle strobe, cannot be stalled
  output logic                     out_valid,
  output logic signed [15:0]       out_neuron_out,
  // Configuration write port
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);
  import nfsu_pkg::*;

  // Control and configuration state.
  state_t                    state_r, state_nxt;
  act_mode_t                 act_mode_r;
  logic [LR_W-1:0]           lr_r;
  logic                      mom_en_r;
  logic [COUNT_W-1:0]        in_count_r;
  logic [PARAM_DEPTH-1:0]    vel_vld_r;

  // Latched item fields.
  logic [PARAM_AW-1:0]       idx_r;
  logic signed [15:0]        val_r;
  logic                      last_r;
  logic                      in_rng_r;

  // Datapath registers.
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [31:0]        prod_r;
  logic signed [15:0]        x_r;
  logic signed [15:0]        param_r;
  logic signed [15:0]        vel_r;
  logic signed [32:0]        mul1_r;
  logic [15:0]               lrb_r;
  logic signed [17:0]        chg0_r;
  logic signed [32:0]        mul2_r;
  logic signed [17:0]        chg_r;

  // Memory ports.
  logic                      par_we;
  logic [PARAM_AW-1:0]       par_waddr;
  logic [15:0]               par_wdata;
  logic [PARAM_AW-1:0]       par_raddr;
  logic [15:0]               par_rdata;
  logic                      vel_we;
  logic [15:0]               vel_rdata;

  logic                      accept;
  opcode_t                   op_in;
  logic                      idx_ok;
  logic                      act_fire;

  // Combinational datapath values.
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_mac_sat;
  logic signed [ACC_W:0]     bias_sum;
  logic signed [ACC_W-1:0]   acc_bias_sat;
  logic [ACC_W:0]            rnd_sum;
  logic signed [15:0]        rnd_sat;
  logic [32:0]               lrb_full;
  logic signed [33:0]        mul1_rnd;
  logic signed [33:0]        mul2_rnd;
  logic signed [17:0]        mom_term;
  logic signed [19:0]        mom_sum;
  logic signed [15:0]        chg_mom;
  logic signed [15:0]        param_new;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  assign op_in  = opcode_t'(in_opcode);
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  // A parameter index is in range when it is at most MAX_INPUTS.
  assign idx_ok = (in_index <= PARAM_AW'(MAX_INPUTS));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_FWD:  state_nxt = ST_F_MUL;
            OP_GRAD: state_nxt = idx_ok ? ST_G_MUL : ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_F_MUL:  state_nxt = ST_F_ACC;
      ST_F_ACC:  state_nxt = last_r ? ST_F_BIAS : ST_IDLE;
      ST_F_BIAS: state_nxt = ST_F_RND;
      ST_F_RND:  state_nxt = ST_F_ACT;
      ST_F_ACT:  state_nxt = ST_IDLE;
      ST_G_MUL:  state_nxt = ST_G_MOM;
      ST_G_MOM:  state_nxt = ST_G_CHG;
      ST_G_CHG:  state_nxt = ST_G_WR;
      ST_G_WR:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory control outputs. The parameter read port addresses the weight of a forward
  // item (index + 1) or the entry of any other item on acceptance; otherwise it sits on
  // the bias, so the bias is already in the read register when the vector ends.
  always_comb begin
    par_raddr = '0;
    par_we    = 1'b0;
    par_waddr = in_index;
    par_wdata = in_value;
    vel_we    = 1'b0;
    act_fire  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          par_raddr = (op_in == OP_FWD) ? PARAM_AW'(in_index + 7'd1) : in_index;
          par_we    = (op_in == OP_LOAD) && idx_ok;
        end
      end
      ST_F_ACT: act_fire = 1'b1;
      ST_G_CHG: vel_we = mom_en_r;
      ST_G_WR: begin
        par_we    = 1'b1;
        par_waddr = idx_r;
        par_wdata = param_new;
      end
      default: begin
        par_raddr = '0;
      end
    endcase
  end

  // Forward arithmetic: saturating accumulate, bias add, round to Q4.12.
  always_comb begin
    acc_sum      = {acc_r[ACC_W-1], acc_r} + {{(ACC_W-31){prod_r[31]}}, prod_r};
    acc_mac_sat  = sat_acc(acc_sum);
    bias_sum     = {acc_r[ACC_W-1], acc_r}
                 + {{(ACC_W-27){par_rdata[15]}}, par_rdata, 12'd0};
    acc_bias_sat = sat_acc(bias_sum);
    rnd_sum      = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(2048);
    // The rounded value fits 16 bits when the bits above it all repeat its sign.
    if (rnd_sum[ACC_W:27] != {(ACC_W-26){rnd_sum[27]}}) begin
      rnd_sat = rnd_sum[ACC_W] ? 16'sh8000 : 16'sh7fff;
    end else begin
      rnd_sat = rnd_sum[27:12];
    end
  end

  // Update arithmetic: plain step, momentum term, new parameter.
  always_comb begin
    lrb_full  = {17'd0, lr_r} * {17'd0, BETA_Q16} + 33'd32768;
    mul1_rnd  = {mul1_r[32], mul1_r} + 34'sd32768;
    mul2_rnd  = {mul2_r[32], mul2_r} + 34'sd32768;
    mom_term  = mul2_rnd[33:16];
    mom_sum   = {{2{chg0_r[17]}}, chg0_r} + {{2{mom_term[17]}}, mom_term};
    chg_mom   = sat16(mom_sum);
    param_new = sat16({{4{param_r[15]}}, param_r} - {{2{chg_r[17]}}, chg_r});
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      act_mode_r <= ACT_NONE;
      lr_r       <= 16'd655;
      mom_en_r   <= 1'b0;
      in_count_r <= 7'd64;
      vel_vld_r  <= '0;
      acc_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ACT_MODE: act_mode_r <= act_mode_t'(cfg_wdata[1:0]);
          CFG_LR:       lr_r       <= cfg_wdata;
          CFG_MOM_EN:   mom_en_r   <= cfg_wdata[0];
          CFG_IN_COUNT: in_count_r <= cfg_wdata[6:0];
          default:      ;
        endcase
      end
      if (vel_we) begin
        vel_vld_r[idx_r] <= 1'b1;
      end
      case (state_r)
        ST_F_ACC:  acc_r <= acc_mac_sat;
        ST_F_BIAS: acc_r <= acc_bias_sat;
        ST_F_RND:  acc_r <= '0;
        default:   acc_r <= acc_r;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= in_index;
      val_r    <= in_value;
      last_r   <= in_last;
      // Samples beyond the count in use, or beyond the table, add nothing.
      in_rng_r <= (in_index < in_count_r) && (in_index < 7'(MAX_INPUTS));
    end
    case (state_r)
      ST_F_MUL: begin
        prod_r <= in_rng_r ? val_r * $signed(par_rdata) : 32'sd0;
      end
      ST_F_RND: begin
        x_r <= rnd_sat;
      end
      ST_G_MUL: begin
        param_r <= par_rdata;
        // A velocity entry that was never written reads as zero.
        vel_r   <= vel_vld_r[idx_r] ? vel_rdata : 16'sd0;
        mul1_r  <= $signed({1'b0, lr_r}) * val_r;
        lrb_r   <= lrb_full[31:16];
      end
      ST_G_MOM: begin
        chg0_r <= mul1_rnd[33:16];
        mul2_r <= $signed({1'b0, lrb_r}) * vel_r;
      end
      ST_G_CHG: begin
        chg_r <= mom_en_r ? {{2{chg_mom[15]}}, chg_mom} : chg0_r;
      end
      default: ;
    endcase
  end

  nfsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_DEPTH)
  ) u_param_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  nfsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_DEPTH)
  ) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (idx_r),
    .wdata (chg_mom),
    .raddr (in_index),
    .rdata (vel_rdata)
  );

  nfsu_act u_act (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (act_fire),
    .mode  (act_mode_r),
    .x     (x_r),
    .valid (out_valid),
    .y     (out_neuron_out)
  );

  // A result appears only right after the activation step of a vector's last sample.
  a_out_after_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_F_ACT))
    else $error("result strobe without a finished forward vector");

  // An accepted forward item always starts the multiply step.
  a_fwd_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_in == OP_FWD) |=> (state_r == ST_F_MUL))
    else $error("forward item did not enter the multiply step");

  // The parameter memory is written only by a load on acceptance or by the update's last step.
  a_par_write: assert property (@(posedge clk) disable iff (!rst_n)
    par_we |-> (state_r == ST_IDLE || state_r == ST_G_WR))
    else $error("parameter write outside load or update write-back");

  // The accumulator is clear after every completed vector.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_RND) |=> (acc_r == '0))
    else $error("accumulator not cleared after a vector");

endmodule

`default_nettype wire

@@ tb/sv/neuron_out_checker.sv @@
`timescale 1ns / 1ps
// Result checker for neuron_forward_and_sgd_update_core: mirrors the parameter and velocity
// tables, predicts every activated output and compares it with the strobed result.
// Depends on nfsu_pkg for the opcode, activation and register codes.

module neuron_out_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_index,
  input  logic signed [15:0] in_value,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic signed [15:0] out_neuron_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 awaited
);
  import nfsu_pkg::*;

  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  logic signed [15:0] weight_mem   [0:MAX_INPUTS];
  logic signed [15:0] velocity_mem [0:MAX_INPUTS];
  longint             mac_sum;
  act_mode_t          act_sel;
  logic [15:0]        step_rate;
  logic               momentum_on;
  logic [6:0]         used_inputs;

  logic signed [15:0] expected_outputs [$];
  logic signed [15:0] want;
  int                 results_seen;

  initial begin
    mismatches   = 0;
    awaited      = 0;
    results_seen = 0;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Sample points of tanh(k/4) in Q4.12.
  function automatic int tanh_point(input int k);
    case (k)
      0:  return 0;
      1:  return 1003;
      2:  return 1893;
      3:  return 2602;
      4:  return 3119;
      5:  return 3475;
      6:  return 3707;
      7:  return 3856;
      8:  return 3949;
      9:  return 4006;
      10: return 4041;
      11: return 4062;
      12: return 4076;
      13: return 4084;
      14: return 4089;
      15: return 4091;
      default: return 4093;
    endcase
  endfunction

  // Interpolated tanh of a non-negative Q4.12 magnitude; flat at 4.0 and above.
  function automatic int tanh_mag(input int a);
    int seg;
    int frac;
    if (a >= 16384) return 4093;
    seg  = a >> 10;
    frac = a & 1023;
    return tanh_point(seg) + (((tanh_point(seg + 1) - tanh_point(seg)) * frac + 512) >> 10);
  endfunction

  function automatic logic signed [15:0] activate(input int x);
    int mag;
    int t;
    mag = (x < 0) ? -x : x;
    case (act_sel)
      ACT_RELU: begin
        return (x < 0) ? 16'sd0 : 16'(x);
      end
      ACT_TANH: begin
        t = tanh_mag(mag);
        return 16'((x < 0) ? -t : t);
      end
      ACT_SIGMOID: begin
        t = tanh_mag(mag >> 1);
        return 16'((x < 0) ? (4097 - t) >> 1 : (4097 + t) >> 1);
      end
      default: begin
        return 16'(x);
      end
    endcase
  endfunction

  task automatic predict_forward(input logic [6:0] idx, input logic signed [15:0] sample,
                                 input logic fin);
    longint rounded;
    if (idx < used_inputs && idx < MAX_INPUTS)
      mac_sum = clip(mac_sum + longint'(sample) * longint'(weight_mem[idx + 1]),
                     ACC_MIN, ACC_MAX);
    if (fin) begin
      mac_sum = clip(mac_sum + longint'(weight_mem[0]) * 64'sd4096, ACC_MIN, ACC_MAX);
      rounded = clip((mac_sum + 2048) >>> 12, -32768, 32767);
      mac_sum = 0;
      expected_outputs.push_back(activate(int'(rounded)));
    end
  endtask

  task automatic apply_gradient(input logic [6:0] idx, input logic signed [15:0] grad);
    longint rate;
    longint beta;
    longint rate_beta;
    longint delta;
    if (idx <= MAX_INPUTS) begin
      rate  = step_rate;
      beta  = BETA_Q16;
      delta = (rate * longint'(grad) + 32768) >>> 16;
      if (momentum_on) begin
        rate_beta = (rate * beta + 32768) >>> 16;
        delta = delta + ((rate_beta * longint'(velocity_mem[idx]) + 32768) >>> 16);
        delta = clip(delta, -32768, 32767);
        velocity_mem[idx] = 16'(delta);
      end
      weight_mem[idx] = 16'(clip(longint'(weight_mem[idx]) - delta, -32768, 32767));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_INPUTS; i++) begin
        weight_mem[i]   = '0;
        velocity_mem[i] = '0;
      end
      mac_sum     = 0;
      act_sel     = ACT_NONE;
      step_rate   = 16'd655;
      momentum_on = 1'b0;
      used_inputs = 7'd64;
      expected_outputs.delete();
    end else begin
      // A result can never belong to an item accepted at the same edge.
      if (out_valid) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          flag_error($sformatf("result %0d: %0d arrived with nothing pending",
                               results_seen, out_neuron_out));
        end else begin
          want = expected_outputs.pop_front();
          if (out_neuron_out !== want)
            flag_error($sformatf("result %0d: neuron_out %0d, predicted %0d",
                                 results_seen, out_neuron_out, want));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ACT_MODE: act_sel     = act_mode_t'(cfg_wdata[1:0]);
          CFG_LR:       step_rate   = cfg_wdata;
          CFG_MOM_EN:   momentum_on = cfg_wdata[0];
          CFG_IN_COUNT: used_inputs = cfg_wdata[6:0];
          default:      ;
        endcase
      end
      if (start && !busy) begin
        case (opcode_t'(in_opcode))
          OP_LOAD: if (in_index <= MAX_INPUTS) weight_mem[in_index] = in_value;
          OP_FWD:  predict_forward(in_index, in_value, in_last);
          OP_GRAD: apply_gradient(in_index, in_value);
          default: ;
        endcase
      end
    end
    awaited <= expected_outputs.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the neuron_forward_and_sgd_update_core testbench: clock, reset, item and register
// stimulus and the verdict. Depends on nfsu_pkg, the core and neuron_out_checker.

module testbench;
  import nfsu_pkg::*;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode  = OP_LOAD;
  logic [6:0]         in_index   = '0;
  logic signed [15:0] in_value   = '0;
  logic               in_last    = 1'b0;
  logic               out_valid;
  logic signed [15:0] out_neuron_out;
  logic               cfg_we     = 1'b0;
  logic [1:0]         cfg_index  = CFG_ACT_MODE;
  logic [15:0]        cfg_wdata  = '0;

  int mismatches;
  int awaited;

  // When set, the item stream runs back to back with no gaps at all.
  bit steady = 1'b0;

  neuron_forward_and_sgd_update_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_neuron_out (out_neuron_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  neuron_out_checker watcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_neuron_out (out_neuron_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  always #10 clk = ~clk;

  // Presents one item and returns at the edge that accepts it. The caller is then at an
  // edge step where start has not been assigned yet, so the next item can follow directly.
  task automatic send_item(input opcode_t op, input logic [6:0] idx, input logic [15:0] val,
                           input logic fin);
    start     <= 1'b1;
    in_opcode <= op;
    in_index  <= idx;
    in_value  <= val;
    in_last   <= fin;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drops start for a random gap about 27 times in a hundred. Gap lengths vary so that
  // the next item lands at different points of the core's internal sequence.
  task automatic pause_maybe();
    if (!steady && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has come out, then waits longer so that a
  // gradient item (which makes no result) has surely finished its table write.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (12) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while the core is idle.
  task automatic write_settings(input act_mode_t act, input logic [15:0] rate,
                                input logic mom, input logic [6:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACT_MODE;
    cfg_wdata <= {14'd0, act};
    @(posedge clk);
    cfg_index <= CFG_LR;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= CFG_MOM_EN;
    cfg_wdata <= {15'd0, mom};
    @(posedge clk);
    cfg_index <= CFG_IN_COUNT;
    cfg_wdata <= {9'd0, count};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Q4.12 values: 40 in a hundred within +-1.0 so the activations see their curved region, some
  // extremes, and the rest spread over the whole 16-bit range.
  function automatic logic [15:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 16'($urandom_range(0, 8191) - 4096);
    if (sel < 55) begin
      case ($urandom_range(0, 4))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        3:       return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom());
  endfunction

  // Parameter index: usually a real entry, now and then an index past the table.
  function automatic logic [6:0] pick_param_index();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(MAX_INPUTS + 1, 127));
    return 7'($urandom_range(0, MAX_INPUTS));
  endfunction

  // Random phase. More than half of the traffic is whole input vectors (samples in order,
  // last on the final one), since only those produce results. The rest is gradient steps,
  // reloads and noise: the unused opcode and stray samples that run into the next vector.
  task automatic random_traffic(input int budget);
    int         issued;
    int         roll;
    int         len;
    logic [6:0] idx;
    issued = 0;
    while (issued < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // Mostly short vectors; once in a while a long one, up to 70 samples, that can cover the full weight range.
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          idx = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127)) : 7'(k);
          send_item(OP_FWD, idx, pick_value(), k == len - 1);
          pause_maybe();
        end
        issued += len;
      end else if (roll < 78) begin
        send_item(OP_GRAD, pick_param_index(), pick_value(), 1'($urandom()));
        pause_maybe();
        issued++;
      end else if (roll < 90) begin
        send_item(OP_LOAD, pick_param_index(), pick_value(), 1'($urandom()));
        pause_maybe();
        issued++;
      end else if (roll < 95) begin
        send_item(OP_NONE, 7'($urandom()), 16'($urandom()), 1'($urandom()));
        pause_maybe();
      end else begin
        send_item(OP_FWD, 7'($urandom()), pick_value(), 1'b0);
        pause_maybe();
        issued++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The parameter table powers up with garbage, so every entry is loaded before anything
    // can read it. The last bit is randomized because a load must ignore it.
    for (int i = 0; i <= MAX_INPUTS; i++) begin
      send_item(OP_LOAD, 7'(i), pick_value(), 1'($urandom()));
      pause_maybe();
    end

    // Directed items under the reset settings (no activation, rate 655, no momentum,
    // all 64 inputs in use).
    // Extreme bias and weights, then a vector whose sum overflows the output range.
    send_item(OP_LOAD, 7'd0, 16'h7FFF, 1'b1);
    send_item(OP_LOAD, 7'd1, 16'h7FFF, 1'b0);
    send_item(OP_LOAD, 7'd64, 16'h8000, 1'b0);
    send_item(OP_FWD, 7'd0, 16'h7FFF, 1'b0);
    send_item(OP_FWD, 7'd63, 16'h8000, 1'b1);
    // Sample indexes past the weight table add nothing but still close the vector.
    send_item(OP_FWD, 7'd64, 16'h1234, 1'b1);
    send_item(OP_FWD, 7'd127, 16'hFFFF, 1'b1);
    // The unused opcode must leave no trace, even with last set.
    send_item(OP_NONE, 7'd5, 16'h4000, 1'b1);
    // Loads and gradients aimed past the table are dropped.
    send_item(OP_LOAD, 7'd65, 16'h1111, 1'b0);
    send_item(OP_LOAD, 7'd127, 16'hFFFF, 1'b1);
    send_item(OP_GRAD, 7'd100, 16'h7FFF, 1'b0);
    // Gradient steps at both table ends, with extreme gradients.
    send_item(OP_GRAD, 7'd0, 16'h7FFF, 1'b1);
    send_item(OP_GRAD, 7'd64, 16'h8000, 1'b0);
    // Most negative bias pulls the output toward the bottom of its range.
    send_item(OP_LOAD, 7'd0, 16'h8000, 1'b0);
    send_item(OP_FWD, 7'd1, 16'h7FFF, 1'b1);
    // A zero bias with no weighted input gives exactly zero.
    send_item(OP_LOAD, 7'd0, 16'h0000, 1'b0);
    send_item(OP_FWD, 7'd70, 16'h7FFF, 1'b1);
    drain();

    // Register phases, extremes first. The zero rate, the zero input count and a count
    // above the table size are all covered here.
    write_settings(ACT_RELU, 16'hFFFF, 1'b1, 7'd1);
    random_traffic(150);
    drain();
    write_settings(ACT_TANH, 16'd1, 1'b0, 7'd8);
    random_traffic(150);
    drain();
    write_settings(ACT_SIGMOID, 16'd0, 1'b1, 7'd0);
    random_traffic(150);
    drain();
    // One long stretch with no gaps on the item stream.
    steady = 1'b1;
    write_settings(ACT_NONE, 16'($urandom_range(1, 65535)), 1'b1, 7'd64);
    random_traffic(150);
    drain();
    steady = 1'b0;
    write_settings(ACT_TANH, 16'($urandom_range(1, 65535)), 1'b1, 7'd127);
    random_traffic(150);
    drain();
    write_settings(ACT_SIGMOID, 16'($urandom_range(1, 65535)), 1'b0, 7'd5);
    random_traffic(150);
    drain();
    write_settings(ACT_RELU, 16'($urandom_range(1, 65535)), 1'($urandom()),
                   7'($urandom_range(1, 64)));
    random_traffic(150);
    drain();
    write_settings(act_mode_t'($urandom_range(0, 3)), 16'($urandom()), 1'($urandom()),
                   7'($urandom_range(0, 127)));
    random_traffic(150);
    drain();

    if (mismatches == 0) begin
      $display("neuron_forward_and_sgd_update_core verification clean");
    end else begin
      $display("neuron_forward_and_sgd_update_core verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #5000000;
    $display("neuron_forward_and_sgd_update_core verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/nfsu_pkg.sv
hw/rtl/nfsu_ram.sv
hw/rtl/nfsu_act.sv
hw/rtl/neuron_forward_and_sgd_update_core.sv
tb/sv/neuron_out_checker.sv
tb/sv/testbench.sv
